/* hw/rtl/fcmd_pkg.sv */
// Shared types, constants and the byte-wide CRC-32 step for the manifest digest block.
package fcmd_pkg;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] ALL_ONES  = 32'hFFFFFFFF;
    localparam logic [2:0]  MAX_FILES_PER_GROUP = 3'd4;

    typedef enum logic [1:0] {
        OP_DATA  = 2'd0,
        OP_FILE  = 2'd1,
        OP_GROUP = 2'd2,
        OP_LIST  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        K_FILE  = 2'd0,
        K_GROUP = 2'd1,
        K_LIST  = 2'd2,
        K_DROP  = 2'd3
    } t_kind;

    // Operand selection for the shared FNV multiply
    typedef enum logic [1:0] {
        M_FILE_ID   = 2'd0,
        M_FILE_SIZE = 2'd1,
        M_FILE_CRC  = 2'd2,
        M_GROUP     = 2'd3
    } t_mul_sel;

    typedef struct packed {
        logic     crc_step;
        logic     take_id;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     emit;
        t_kind    kind;
    } t_cmd;

    typedef struct packed {
        logic group_full;
        logic out_free;
    } t_stat;

    // Reflected CRC-32 over one byte, LSB first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

/* hw/rtl/file_crc_manifest_digest.sv */
// Top level of the file CRC manifest digest: sequencer plus datapath.
//
//   channel | handshake          | payload
//   --------+--------------------+---------------------------------------------
//   input   | i_valid / o_stall  | i_op, i_data_byte, i_file_id
//   output  | o_valid / i_stall  | o_kind, o_rec_file_id, file/group/list fields
//
// Steps per accepted transaction: a data byte is one byte-wide CRC-32 step
// and leaves o_stall low. End of file runs the accept, three chained FNV
// multiplies through one shared 32x32 multiply register, then the hand-off;
// a full group skips them. End of group runs one multiply, end of list none.
// A finished record waits in the output register; new transactions are taken
// while it waits, and only the next record hand-off holds on i_stall.
// Reset is synchronous, active low.
module file_crc_manifest_digest import fcmd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_file_id,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_rec_file_id,
    output logic [31:0] o_file_bytes,
    output logic [31:0] o_file_crc,
    output logic [31:0] o_group_revision,
    output logic [31:0] o_group_total_bytes,
    output logic [2:0]  o_group_file_count,
    output logic [31:0] o_list_revision,
    output logic [15:0] o_groups_listed
);

    t_cmd  cmd;
    t_stat stat;

    fcmd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    fcmd_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_data_byte         (i_data_byte),
        .i_file_id           (i_file_id),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_stall             (i_stall),
        .o_valid             (o_valid),
        .o_kind              (o_kind),
        .o_rec_file_id       (o_rec_file_id),
        .o_file_bytes        (o_file_bytes),
        .o_file_crc          (o_file_crc),
        .o_group_revision    (o_group_revision),
        .o_group_total_bytes (o_group_total_bytes),
        .o_group_file_count  (o_group_file_count),
        .o_list_revision     (o_list_revision),
        .o_groups_listed     (o_groups_listed)
    );

endmodule

/* hw/rtl/fcmd_ctrl.sv */
// Sequencer: input handshake, FNV multiply steps and result hand-off.
module fcmd_ctrl import fcmd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_op,
    output logic       o_stall,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_F1,
        S_F2,
        S_F3,
        S_G,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    t_kind  r_kind, n_kind;
    logic   accept;
    t_op    op;

    assign op      = t_op'(i_op);
    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state         = r_state;
        n_kind          = r_kind;
        o_cmd           = '0;
        o_cmd.kind      = r_kind;
        o_cmd.mul_sel   = M_FILE_ID;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.take_id = 1'b1;
                    case (op)
                        OP_DATA: o_cmd.crc_step = 1'b1;
                        OP_FILE: begin
                            if (i_stat.group_full) begin
                                n_kind  = K_DROP;
                                n_state = S_EMIT;
                            end else begin
                                n_kind  = K_FILE;
                                n_state = S_F1;
                            end
                        end
                        OP_GROUP: begin
                            n_kind  = K_GROUP;
                            n_state = S_G;
                        end
                        default: begin
                            n_kind  = K_LIST;
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_F1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = M_FILE_ID;
                n_state       = S_F2;
            end
            S_F2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = M_FILE_SIZE;
                n_state       = S_F3;
            end
            S_F3: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = M_FILE_CRC;
                n_state       = S_EMIT;
            end
            S_G: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = M_GROUP;
                n_state       = S_EMIT;
            end
            S_EMIT: begin
                // wait for a free output register
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= K_FILE;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

endmodule

/* hw/rtl/fcmd_dp.sv */
// Datapath: CRC and counters, FNV multiply register, digest state and output register.
module fcmd_dp import fcmd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_file_id,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_rec_file_id,
    output logic [31:0] o_file_bytes,
    output logic [31:0] o_file_crc,
    output logic [31:0] o_group_revision,
    output logic [31:0] o_group_total_bytes,
    output logic [2:0]  o_group_file_count,
    output logic [31:0] o_list_revision,
    output logic [15:0] o_groups_listed
);

    logic [31:0] r_crc, r_cnt, r_gdig, r_gsum, r_ldig, r_acc;
    logic [2:0]  r_gfiles;
    logic [15:0] r_gcnt;
    logic [7:0]  r_id;
    logic [31:0] file_crc;
    logic [31:0] mul_in;

    // output register
    logic        r_o_valid;
    logic [1:0]  r_o_kind;
    logic [7:0]  r_o_id;
    logic [31:0] r_o_bytes, r_o_crc, r_o_grev, r_o_gsum, r_o_lrev;
    logic [2:0]  r_o_gcount;
    logic [15:0] r_o_gcnt;

    assign file_crc          = r_crc ^ ALL_ONES;
    assign o_stat.group_full = (r_gfiles >= MAX_FILES_PER_GROUP);
    assign o_stat.out_free   = !r_o_valid || !i_stall;

    // FNV-1a step operand
    always_comb begin
        case (i_cmd.mul_sel)
            M_FILE_ID:   mul_in = r_gdig ^ {24'd0, r_id};
            M_FILE_SIZE: mul_in = r_acc ^ r_cnt;
            M_FILE_CRC:  mul_in = r_acc ^ file_crc;
            default:     mul_in = r_ldig ^ r_gdig;
        endcase
    end

    // Multiply register
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_acc <= 32'(mul_in * FNV_PRIME);
        end
        if (i_cmd.take_id) begin
            r_id <= i_file_id;
        end
    end

    // Digest state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc    <= ALL_ONES;
            r_cnt    <= '0;
            r_gdig   <= FNV_BASIS;
            r_gsum   <= '0;
            r_gfiles <= '0;
            r_ldig   <= FNV_BASIS;
            r_gcnt   <= '0;
        end else if (i_cmd.crc_step) begin
            r_crc <= crc_byte(r_crc, i_data_byte);
            r_cnt <= r_cnt + 32'd1;
        end else if (i_cmd.emit) begin
            case (i_cmd.kind)
                K_FILE: begin
                    r_gdig   <= r_acc;
                    r_gsum   <= r_gsum + r_cnt;
                    r_gfiles <= r_gfiles + 3'd1;
                    r_crc    <= ALL_ONES;
                    r_cnt    <= '0;
                end
                K_DROP: begin
                    r_crc <= ALL_ONES;
                    r_cnt <= '0;
                end
                K_GROUP: begin
                    r_ldig   <= r_acc;
                    r_gcnt   <= r_gcnt + 16'd1;
                    r_gdig   <= FNV_BASIS;
                    r_gsum   <= '0;
                    r_gfiles <= '0;
                end
                default: begin
                    r_crc    <= ALL_ONES;
                    r_cnt    <= '0;
                    r_gdig   <= FNV_BASIS;
                    r_gsum   <= '0;
                    r_gfiles <= '0;
                    r_ldig   <= FNV_BASIS;
                    r_gcnt   <= '0;
                end
            endcase
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    // Output payload, fields outside the record kind are zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_kind   <= i_cmd.kind;
            r_o_id     <= '0;
            r_o_bytes  <= '0;
            r_o_crc    <= '0;
            r_o_grev   <= '0;
            r_o_gsum   <= '0;
            r_o_gcount <= '0;
            r_o_lrev   <= '0;
            r_o_gcnt   <= '0;
            case (i_cmd.kind)
                K_FILE, K_DROP: begin
                    r_o_id    <= r_id;
                    r_o_bytes <= r_cnt;
                    r_o_crc   <= file_crc;
                end
                K_GROUP: begin
                    r_o_grev   <= r_gdig;
                    r_o_gsum   <= r_gsum;
                    r_o_gcount <= r_gfiles;
                end
                default: begin
                    r_o_lrev <= r_ldig;
                    r_o_gcnt <= r_gcnt;
                end
            endcase
        end
    end

    assign o_valid             = r_o_valid;
    assign o_kind              = r_o_kind;
    assign o_rec_file_id       = r_o_id;
    assign o_file_bytes        = r_o_bytes;
    assign o_file_crc          = r_o_crc;
    assign o_group_revision    = r_o_grev;
    assign o_group_total_bytes = r_o_gsum;
    assign o_group_file_count  = r_o_gcount;
    assign o_list_revision     = r_o_lrev;
    assign o_groups_listed     = r_o_gcnt;

endmodule
